[src/fig_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fig_pkg: shared types and constants of the information gain block
// Holds the default sizes, the fixed point constants and the request and
// response structs of the shared multiplier.
// ----------------------------------------------------------------------------
package fig_pkg;

    // Defaults of the top level parameters.
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_COUNT_WIDTH = 32;

    // Fixed widths of the datapath.
    localparam int KEY_W   = 32;
    localparam int OPND_W  = 64;
    localparam int PROD_W  = 128;
    localparam int FRAC_W  = 30;
    localparam int EXP_W   = 6;
    localparam int CLIP_LG = 40;
    localparam int GAIN_W  = 32;

    // ln(2) in unsigned Q0.32.
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F7;

    // Request to the shared multiplier.
    typedef struct packed {
        logic              start;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
    } mul_req_t;

    // Response of the shared multiplier.
    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] p;
    } mul_rsp_t;

endpackage
`default_nettype wire

[src/fig_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fig_ram: single write port, single read port table memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fig_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 97
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[src/fig_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fig_mul: shared 64 by 64 bit multiplier
// Builds the full product from four 32 by 32 bit partial products, one per
// cycle, with a register after the multiplier.
// ----------------------------------------------------------------------------
module fig_mul
    import fig_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic              busy_reg;
    logic [2:0]        cnt_reg;
    logic [OPND_W-1:0] a_reg;
    logic [OPND_W-1:0] b_reg;
    logic [63:0]       pp_reg;
    logic [63:0]       pp_next;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] pp_shifted;
    logic              done_reg;
    logic [31:0]       a_half;
    logic [31:0]       b_half;

    // Operand halves for the partial product of this step.
    always_comb
    begin
        case (cnt_reg)
            3'd0:
            begin
                a_half = a_reg[31:0];
                b_half = b_reg[31:0];
            end
            3'd1:
            begin
                a_half = a_reg[31:0];
                b_half = b_reg[63:32];
            end
            3'd2:
            begin
                a_half = a_reg[63:32];
                b_half = b_reg[31:0];
            end
            default:
            begin
                a_half = a_reg[63:32];
                b_half = b_reg[63:32];
            end
        endcase
        pp_next = a_half * b_half;
    end

    // Alignment of the partial product computed in the previous step.
    always_comb
    begin
        case (cnt_reg)
            3'd1:    pp_shifted = PROD_W'(pp_reg);
            3'd2:    pp_shifted = PROD_W'(pp_reg) << 32;
            3'd3:    pp_shifted = PROD_W'(pp_reg) << 32;
            3'd4:    pp_shifted = PROD_W'(pp_reg) << 64;
            default: pp_shifted = '0;
        endcase
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end
            else
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (req.start)
            begin
                a_reg   <= req.a;
                b_reg   <= req.b;
                acc_reg <= '0;
            end
        end
        else
        begin
            pp_reg  <= pp_next;
            acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule
`default_nettype wire

[src/fig_xlog.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fig_xlog: x times log2(x) sequencer
// Normalises x one bit a cycle, takes 30 fraction bits of log2 by repeated
// squaring on the shared multiplier, then multiplies x by the logarithm.
// ----------------------------------------------------------------------------
module fig_xlog
    import fig_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [OPND_W-1:0] x,
    output logic                   done,
    output logic      [PROD_W-1:0] t,
    output mul_req_t               mul_req,
    input  wire mul_rsp_t          mul_rsp
);

    localparam logic [1:0] X_IDLE = 2'd0;
    localparam logic [1:0] X_NORM = 2'd1;
    localparam logic [1:0] X_SQ   = 2'd2;
    localparam logic [1:0] X_TMUL = 2'd3;

    logic [1:0]        state_reg;
    logic [OPND_W-1:0] x_reg;
    logic [OPND_W-1:0] m_reg;
    logic [EXP_W-1:0]  e_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [4:0]        cnt_reg;
    logic              req_start_reg;
    logic [OPND_W-1:0] req_a_reg;
    logic [OPND_W-1:0] req_b_reg;
    logic [PROD_W-1:0] t_reg;
    logic              done_reg;
    logic [OPND_W-1:0] sq;
    logic [OPND_W-1:0] m_next;
    logic [FRAC_W-1:0] frac_next;

    // One squaring step: keep bits 125..62 of the square, take one bit.
    always_comb
    begin
        sq        = mul_rsp.p[125:62];
        frac_next = {frac_reg[FRAC_W-2:0], sq[63]};
        m_next    = sq[63] ? (sq >> 1) : sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= X_IDLE;
            req_start_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            case (state_reg)
                X_IDLE:
                begin
                    if (start)
                    begin
                        if (x <= OPND_W'(1))
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= X_NORM;
                        end
                    end
                end
                X_NORM:
                begin
                    if (m_reg[62])
                    begin
                        req_start_reg <= 1'b1;
                        state_reg     <= X_SQ;
                    end
                end
                X_SQ:
                begin
                    if (mul_rsp.done)
                    begin
                        req_start_reg <= 1'b1;
                        if (cnt_reg == 5'd29)
                        begin
                            state_reg <= X_TMUL;
                        end
                    end
                end
                X_TMUL:
                begin
                    if (mul_rsp.done)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= X_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= X_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            X_IDLE:
            begin
                if (start)
                begin
                    x_reg    <= x;
                    m_reg    <= x;
                    e_reg    <= EXP_W'(62);
                    frac_reg <= '0;
                    cnt_reg  <= '0;
                    t_reg    <= '0;
                end
            end
            X_NORM:
            begin
                if (m_reg[62])
                begin
                    req_a_reg <= m_reg;
                    req_b_reg <= m_reg;
                end
                else
                begin
                    m_reg <= m_reg << 1;
                    e_reg <= e_reg - EXP_W'(1);
                end
            end
            X_SQ:
            begin
                if (mul_rsp.done)
                begin
                    m_reg    <= m_next;
                    frac_reg <= frac_next;
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd29)
                    begin
                        req_a_reg <= x_reg;
                        req_b_reg <= OPND_W'({e_reg, frac_next});
                    end
                    else
                    begin
                        req_a_reg <= m_next;
                        req_b_reg <= m_next;
                    end
                end
            end
            X_TMUL:
            begin
                if (mul_rsp.done)
                begin
                    t_reg <= mul_rsp.p;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign mul_req.start = req_start_reg;
    assign mul_req.a     = req_a_reg;
    assign mul_req.b     = req_b_reg;
    assign done          = done_reg;
    assign t             = t_reg;

endmodule
`default_nettype wire

[src/fig_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fig_div: bit-serial restoring divider
// Divides a 128-bit magnitude by the sample count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fig_div
    import fig_pkg::*;
#(
    parameter int DEN_W = 33
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] num,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   done,
    output logic      [PROD_W-1:0] quo
);

    logic              busy_reg;
    logic [6:0]        cnt_reg;
    logic              done_reg;
    logic [PROD_W-1:0] num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W:0]    rem_sh;
    logic              ge;
    logic [DEN_W:0]    rem_new;

    // One restoring step; the quotient bit shifts in behind the dividend.
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[PROD_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_new = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end
            else
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            if (start)
            begin
                num_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
            end
        end
        else
        begin
            num_reg <= {num_reg[PROD_W-2:0], ge};
            rem_reg <= rem_new[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule
`default_nettype wire

[src/feature_information_gain_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// feature_information_gain_top: information gain of a binary label
// Counts labelled samples per feature value in a linear probing table and
// reports the information gain of the label in nats, signed Q2.30.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. After reset the
// block clears every table slot with busy high. A sample request finds its
// home slot in ST_MOD and ST_HOME (a reciprocal multiplication by the table
// depth) and then reads and compares each probed slot in ST_PRD and ST_PCMP
// through the single table read port. A finish request first evaluates
// x*log2(x) for the sample count and the two label totals, then walks the
// whole table, reading each slot in ST_FRD and ST_FCHK; each occupied slot
// costs three more x*log2(x) evaluations, all on one shared 64 by 64 bit
// multiplier, followed by a bit-serial division by the sample count and a
// final multiply by ln 2. The result appears on info_gain, positive_total,
// negative_total and table_overflowed with done high for exactly one cycle
// and cannot be held off; capture it then. The table and totals are then
// empty again.
// ----------------------------------------------------------------------------
module feature_information_gain_top
    import fig_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     kind,
    input  wire logic                     is_positive,
    input  wire logic [KEY_W-1:0]         feature_key,
    output logic                          done,
    output logic signed [GAIN_W-1:0]      info_gain,
    output logic        [31:0]            positive_total,
    output logic        [31:0]            negative_total,
    output logic                          table_overflowed
);

    localparam int IDXW  = $clog2(TABLE_DEPTH);
    localparam int CW    = COUNT_WIDTH;
    localparam int ENT_W = 1 + KEY_W + 2 * CW;
    localparam int SUM_W = CW + 1;

    localparam logic [IDXW-1:0] IDX_LAST   = IDXW'(TABLE_DEPTH - 1);
    localparam logic [IDXW:0]   PROBE_LAST = (IDXW+1)'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0]   CNT_MAX    = {CW{1'b1}};

    // Reciprocal of the table depth: ceil(2^(32+IDXW) / depth), which lies
    // between 2^32 and 2^33, so only its low 32 bits need a multiplier.
    localparam int              RCP_SH   = KEY_W + IDXW;
    localparam logic [63:0]     RCP_FULL = ((64'd1 << RCP_SH) + 64'(TABLE_DEPTH) - 64'd1)
                                           / 64'(TABLE_DEPTH);
    localparam logic [KEY_W-1:0] RCP_LO  = RCP_FULL[KEY_W-1:0];
    localparam logic [IDXW-1:0] DEPTH_LO = IDXW'(TABLE_DEPTH);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MOD   = 4'd2;
    localparam logic [3:0] ST_PRD   = 4'd3;
    localparam logic [3:0] ST_PCMP  = 4'd4;
    localparam logic [3:0] ST_TERM  = 4'd5;
    localparam logic [3:0] ST_TWAIT = 4'd6;
    localparam logic [3:0] ST_FRD   = 4'd7;
    localparam logic [3:0] ST_FCHK  = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_DWAIT = 4'd10;
    localparam logic [3:0] ST_MUL   = 4'd11;
    localparam logic [3:0] ST_MWAIT = 4'd12;
    localparam logic [3:0] ST_HOME  = 4'd13;

    // Control state.
    logic [3:0]        state_reg;
    logic [IDXW-1:0]   idx_reg;
    logic [IDXW:0]     probe_reg;
    logic [1:0]        term_reg;
    logic              head_reg;
    logic [CW-1:0]     tot_pos_reg;
    logic [CW-1:0]     tot_neg_reg;
    logic              ovf_reg;
    logic              done_reg;

    // Payload registers.
    logic              smp_pos_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [IDXW-1:0]   quo_lo_reg;
    logic [CW-1:0]     ent_p_reg;
    logic [CW-1:0]     ent_q_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [CLIP_LG:0]  qc_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [31:0]       pos_out_reg;
    logic [31:0]       neg_out_reg;
    logic              ovf_out_reg;

    // Table entry fields.
    logic              wr_en;
    logic [ENT_W-1:0]  wr_data;
    logic [ENT_W-1:0]  rd_data;
    logic              rd_valid;
    logic [KEY_W-1:0]  rd_key;
    logic [CW-1:0]     rd_pos;
    logic [CW-1:0]     rd_neg;

    // Arithmetic units.
    mul_req_t          mul_req;
    mul_req_t          xl_req;
    mul_req_t          top_req;
    mul_rsp_t          mul_rsp;
    logic              xl_start;
    logic              xl_done;
    logic [PROD_W-1:0] xl_t;
    logic [SUM_W-1:0]  opnd;
    logic              div_start;
    logic              div_done;
    logic [PROD_W-1:0] div_quo;

    // Combinational helpers.
    logic              accept;
    logic [SUM_W-1:0]  n_total;
    logic              acc_neg;
    logic [PROD_W-1:0] acc_mag;
    logic [63:0]       rcp_part;
    logic [64:0]       rcp_sum;
    logic [IDXW-1:0]   home_idx;
    logic [63:0]       g;
    logic [GAIN_W-1:0] gain_next;
    logic              term_adds;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c == CNT_MAX) ? c : c + CW'(1);
    endfunction

    function automatic logic [31:0] clip32(input logic [CW-1:0] c);
        logic [63:0] ext;
        ext = 64'(c);
        return (ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : ext[31:0];
    endfunction

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign n_total = SUM_W'(tot_pos_reg) + SUM_W'(tot_neg_reg);

    assign rd_valid = rd_data[ENT_W-1];
    assign rd_key   = rd_data[ENT_W-2 -: KEY_W];
    assign rd_pos   = rd_data[2*CW-1:CW];
    assign rd_neg   = rd_data[CW-1:0];

    // Home slot: the quotient comes from the reciprocal product, and the
    // remainder is below the depth, so its low index bits are enough.
    always_comb
    begin
        rcp_part = 64'(key_reg) * 64'(RCP_LO);
        rcp_sum  = {1'b0, key_reg, 32'd0} + 65'(rcp_part);
        home_idx = key_reg[IDXW-1:0] - quo_lo_reg * DEPTH_LO;
    end

    // Table writes: clearing, new or updated entries, and release on finish.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_PCMP:
            begin
                if (!rd_valid)
                begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, key_reg, CW'(smp_pos_reg), CW'(!smp_pos_reg)};
                end
                else if (rd_key == key_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = smp_pos_reg ? {1'b1, key_reg, sat_inc(rd_pos), rd_neg}
                                          : {1'b1, key_reg, rd_pos, sat_inc(rd_neg)};
                end
            end
            ST_FCHK:
            begin
                wr_en = rd_valid;
            end
            default:
            begin
            end
        endcase
    end

    // Operand of the next x*log2(x) term and whether it adds or subtracts.
    always_comb
    begin
        if (head_reg)
        begin
            case (term_reg)
                2'd0:    opnd = n_total;
                2'd1:    opnd = SUM_W'(tot_pos_reg);
                default: opnd = SUM_W'(tot_neg_reg);
            endcase
            term_adds = (term_reg == 2'd0);
        end
        else
        begin
            case (term_reg)
                2'd0:    opnd = SUM_W'(ent_p_reg);
                2'd1:    opnd = SUM_W'(ent_q_reg);
                default: opnd = SUM_W'(ent_p_reg) + SUM_W'(ent_q_reg);
            endcase
            term_adds = (term_reg != 2'd2);
        end
    end

    // Sign and magnitude of the accumulated difference.
    assign acc_neg = acc_reg[PROD_W-1];
    assign acc_mag = acc_neg ? PROD_W'(-acc_reg) : PROD_W'(acc_reg);

    // Scale by ln 2, then saturate to Q2.30 with the sign applied.
    always_comb
    begin
        g = mul_rsp.p[95:32];
        if (acc_neg)
        begin
            gain_next = (g >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - g[31:0]);
        end
        else
        begin
            gain_next = (g > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : g[31:0];
        end
    end

    // Shared multiplier: the final scaling has it, otherwise the log sequencer.
    assign xl_start      = (state_reg == ST_TERM);
    assign div_start     = (state_reg == ST_DIV);
    assign top_req.start = (state_reg == ST_MUL);
    assign top_req.a     = OPND_W'(qc_reg);
    assign top_req.b     = OPND_W'(LN2_Q32);
    assign mul_req = ((state_reg == ST_MUL) || (state_reg == ST_MWAIT)) ? top_req : xl_req;

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            probe_reg   <= '0;
            term_reg    <= '0;
            head_reg    <= 1'b0;
            tot_pos_reg <= '0;
            tot_neg_reg <= '0;
            ovf_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDXW'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!kind)
                        begin
                            if (is_positive)
                            begin
                                tot_pos_reg <= sat_inc(tot_pos_reg);
                            end
                            else
                            begin
                                tot_neg_reg <= sat_inc(tot_neg_reg);
                            end
                            state_reg <= ST_MOD;
                        end
                        else if (n_total == '0)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            head_reg  <= 1'b1;
                            term_reg  <= '0;
                            state_reg <= ST_TERM;
                        end
                    end
                end
                ST_MOD:
                begin
                    state_reg <= ST_HOME;
                end
                ST_HOME:
                begin
                    idx_reg   <= home_idx;
                    probe_reg <= '0;
                    state_reg <= ST_PRD;
                end
                ST_PRD:
                begin
                    state_reg <= ST_PCMP;
                end
                ST_PCMP:
                begin
                    if (!rd_valid || (rd_key == key_reg))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (probe_reg == PROBE_LAST)
                    begin
                        ovf_reg   <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        probe_reg <= probe_reg + (IDXW+1)'(1);
                        idx_reg   <= (idx_reg == IDX_LAST) ? '0 : idx_reg + IDXW'(1);
                        state_reg <= ST_PRD;
                    end
                end
                ST_TERM:
                begin
                    state_reg <= ST_TWAIT;
                end
                ST_TWAIT:
                begin
                    if (xl_done)
                    begin
                        if (term_reg == 2'd2)
                        begin
                            if (head_reg)
                            begin
                                head_reg  <= 1'b0;
                                idx_reg   <= '0;
                                state_reg <= ST_FRD;
                            end
                            else if (idx_reg == IDX_LAST)
                            begin
                                state_reg <= ST_DIV;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + IDXW'(1);
                                state_reg <= ST_FRD;
                            end
                        end
                        else
                        begin
                            term_reg  <= term_reg + 2'd1;
                            state_reg <= ST_TERM;
                        end
                    end
                end
                ST_FRD:
                begin
                    state_reg <= ST_FCHK;
                end
                ST_FCHK:
                begin
                    if (rd_valid)
                    begin
                        term_reg  <= '0;
                        state_reg <= ST_TERM;
                    end
                    else if (idx_reg == IDX_LAST)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDXW'(1);
                        state_reg <= ST_FRD;
                    end
                end
                ST_DIV:
                begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_MWAIT;
                end
                ST_MWAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        done_reg    <= 1'b1;
                        tot_pos_reg <= '0;
                        tot_neg_reg <= '0;
                        ovf_reg     <= 1'b0;
                        idx_reg     <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // An empty finish request also clears the overflow flag.
            if (accept && kind && (n_total == '0))
            begin
                ovf_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    smp_pos_reg <= is_positive;
                    key_reg     <= feature_key;
                    acc_reg     <= '0;
                    if (kind && (n_total == '0))
                    begin
                        gain_reg    <= '0;
                        pos_out_reg <= '0;
                        neg_out_reg <= '0;
                        ovf_out_reg <= ovf_reg;
                    end
                end
            end
            ST_MOD:
            begin
                quo_lo_reg <= rcp_sum[RCP_SH +: IDXW];
            end
            ST_TWAIT:
            begin
                if (xl_done)
                begin
                    acc_reg <= term_adds ? (acc_reg + $signed(xl_t))
                                         : (acc_reg - $signed(xl_t));
                end
            end
            ST_FCHK:
            begin
                ent_p_reg <= rd_pos;
                ent_q_reg <= rd_neg;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (div_quo > (PROD_W'(1) << CLIP_LG))
                    begin
                        qc_reg <= (CLIP_LG+1)'(1) << CLIP_LG;
                    end
                    else
                    begin
                        qc_reg <= div_quo[CLIP_LG:0];
                    end
                end
            end
            ST_MWAIT:
            begin
                if (mul_rsp.done)
                begin
                    gain_reg    <= gain_next;
                    pos_out_reg <= clip32(tot_pos_reg);
                    neg_out_reg <= clip32(tot_neg_reg);
                    ovf_out_reg <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    fig_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    fig_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    fig_xlog u_xlog (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (xl_start),
        .x       (OPND_W'(opnd)),
        .done    (xl_done),
        .t       (xl_t),
        .mul_req (xl_req),
        .mul_rsp (mul_rsp)
    );

    fig_div #(
        .DEN_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_mag),
        .den   (n_total),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign done             = done_reg;
    assign info_gain        = $signed(gain_reg);
    assign positive_total   = pos_out_reg;
    assign negative_total   = neg_out_reg;
    assign table_overflowed = ovf_out_reg;

`ifndef SYNTHESIS
    // A result is only shown once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A sample request never yields a result.
    a_sample_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !kind) |=> !done)
        else $error("result after a sample request");

    // The shared multiplier never sees two requesters at once.
    a_mul_shared: assert property (@(posedge clk) disable iff (!rst_n)
        !(xl_req.start && top_req.start))
        else $error("multiplier request collision");

    // No samples means no gain.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (positive_total == 32'd0) && (negative_total == 32'd0))
            |-> (info_gain == 32'sd0))
        else $error("nonzero gain without samples");
`endif

endmodule
`default_nettype wire
